[sv/lmsf_pkg.sv]
// Shared types, constants and control word layout for the LMS adaptive FIR filter.
package lmsf_pkg;

    localparam int TAPS_DEF   = 32;

    localparam int SAMPLE_W   = 16;   // Q4.11 samples
    localparam int WEIGHT_W   = 32;   // Q8.23 weights
    localparam int STEP_W     = 16;   // Q0.16 step size
    localparam int LIMIT_W    = 15;   // Q4.11 magnitude bound
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 2 * SAMPLE_W;
    localparam int M_TDATA_W  = SAMPLE_W;

    localparam int ERR_W      = SAMPLE_W + 1;          // error before scaling
    localparam int SE_W       = 2 * ERR_W;             // step * error
    localparam int PROD_W     = SE_W + SAMPLE_W;       // shared multiplier output
    localparam int ACC_SHIFT  = 23;                    // Q.34 -> Q4.11
    localparam int UPD_SHIFT  = 15;                    // Q.38 -> Q8.23
    localparam int SUM_W      = PROD_W + 1;
    localparam int SHR_W      = SUM_W - UPD_SHIFT;

    localparam logic [STEP_W-1:0]    STEP_RESET  = 16'd655;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 15'd20480;
    localparam logic [UPD_SHIFT-1:0] UPD_HALF    = 15'h4000;
    localparam logic [WEIGHT_W-1:0]  W_MAX       = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_W-1:0]  W_MIN       = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_SIZE = 1'b0,
        REG_DIV_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_MAC       = 3'd1,
        ST_MAC_DRAIN = 3'd2,
        ST_CHECK     = 3'd3,
        ST_SCALE     = 3'd4,
        ST_UPD       = 3'd5,
        ST_UPD_DRAIN = 3'd6,
        ST_EMIT      = 3'd7
    } step_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_HOLD_IN,
        COND_LOOP,
        COND_HOLD_PIPE,
        COND_BR_DIV,
        COND_HOLD_OUT
    } cond_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_ISSUE,
        ACT_CHECK,
        ACT_SCALE,
        ACT_EMIT
    } act_t;

    typedef struct packed {
        act_t  act;
        logic  pass;     // 0: filter pass, 1: weight update pass
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic idx_last;
        logic pipe_busy;
        logic diverge;
        logic out_free;
    } stat_t;

endpackage

[sv/lms_adaptive_fir_filter.sv]
// LMS adaptive FIR filter top level: datapath, tap and weight stores, ports.
//
// Each input transfer carries one reference sample and one error-sensor sample
// (Q4.11). The reference enters a TAPS-deep delay line, the output is the dot
// product of that line with the Q8.23 weights, rounded to Q4.11. An output
// beyond +-divergence_limit gives 0 with the diverged flag set and clears every
// weight; otherwise each weight moves by step_size * error * tap. One shared
// 34x16 multiplier makes two passes over the taps (only the filter pass when
// the output diverges), and a result waiting for m_tready holds back the next
// acceptance. One item is in flight at a time; a finished result sits in the
// output register while the next item is taken. No clearing pass after reset:
// tap and weight entries carry valid bits, so the block is ready on the first cycle.
// Configuration may be written only while the block is idle.
module lms_adaptive_fir_filter #(
    parameter int TAPS = lmsf_pkg::TAPS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_we,
    input  logic [lmsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lmsf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lmsf_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] reference_sample, [31:16] error_sample
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lmsf_pkg::M_TDATA_W-1:0]   m_tdata,   // [15:0] filter_output
    output logic                             m_tuser    // [0] diverged
);

    localparam int IdxW  = $clog2(TAPS);
    localparam int AccW  = lmsf_pkg::PROD_W + IdxW;    // room for TAPS products
    localparam int CmpW  = AccW + 1;
    localparam int BndW  = lmsf_pkg::LIMIT_W + lmsf_pkg::ACC_SHIFT;
    localparam int SW    = lmsf_pkg::SAMPLE_W;
    localparam int WW    = lmsf_pkg::WEIGHT_W;
    localparam int PrW   = lmsf_pkg::PROD_W;
    localparam int SeW   = lmsf_pkg::SE_W;
    localparam logic [IdxW-1:0] IdxLast = IdxW'(TAPS - 1);

    lmsf_pkg::ctrl_t ctrl;
    lmsf_pkg::stat_t stat;

    lmsf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat_i  (stat),
        .ctrl_o  (ctrl)
    );

    // ---------------- configuration registers ----------------
    logic [lmsf_pkg::STEP_W-1:0]  step_reg;
    logic [lmsf_pkg::LIMIT_W-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= lmsf_pkg::STEP_RESET;
            limit_reg <= lmsf_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            case (lmsf_pkg::cfg_reg_t'(cfg_index))
                lmsf_pkg::REG_STEP_SIZE: step_reg  <= cfg_wdata[lmsf_pkg::STEP_W-1:0];
                lmsf_pkg::REG_DIV_LIMIT: limit_reg <= cfg_wdata[lmsf_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- control decode ----------------
    logic in_fire, issue, out_free, load, check, scale, emit;

    assign s_tready = (ctrl.act == lmsf_pkg::ACT_LOAD);
    assign in_fire  = s_tvalid && s_tready;
    assign load     = in_fire;
    assign issue    = (ctrl.act == lmsf_pkg::ACT_ISSUE);
    assign check    = (ctrl.act == lmsf_pkg::ACT_CHECK);
    assign scale    = (ctrl.act == lmsf_pkg::ACT_SCALE);
    assign out_free = !m_tvalid || m_tready;
    assign emit     = (ctrl.act == lmsf_pkg::ACT_EMIT) && out_free;

    // ---------------- address generation ----------------
    // tap line is a circular buffer; head points at the newest sample,
    // tap i lives at head - i (mod TAPS)
    logic [IdxW-1:0] head_reg, head_next;
    logic [IdxW-1:0] tap_ptr_reg, tap_ptr_dec;
    logic [IdxW-1:0] idx_reg;
    logic            idx_last;

    assign head_next   = (head_reg == IdxLast) ? '0 : head_reg + IdxW'(1);
    assign tap_ptr_dec = (tap_ptr_reg == '0) ? IdxLast : tap_ptr_reg - IdxW'(1);
    assign idx_last    = (idx_reg == IdxLast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
        end else if (load) begin
            head_reg <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tap_ptr_reg <= head_next;
            idx_reg     <= '0;
        end else if (scale) begin
            tap_ptr_reg <= head_reg;
            idx_reg     <= '0;
        end else if (issue) begin
            tap_ptr_reg <= tap_ptr_dec;
            if (!idx_last) begin
                idx_reg <= idx_reg + IdxW'(1);
            end
        end
    end

    // ---------------- stores ----------------
    logic signed [SW-1:0] tap_mem [TAPS];
    logic signed [WW-1:0] w_mem   [TAPS];
    logic [TAPS-1:0]      tap_vld_reg;
    logic [TAPS-1:0]      w_vld_reg;
    logic signed [SW-1:0] tap_rd_reg;
    logic signed [WW-1:0] w_rd_reg;
    logic                 tap_rv_reg, w_rv_reg;

    logic                 div;
    logic                 w_wr;
    logic signed [WW-1:0] w_new;
    logic [IdxW-1:0]      p2_idx_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            tap_mem[head_next] <= s_tdata[SW-1:0];
        end
        tap_rd_reg <= tap_mem[tap_ptr_reg];
        tap_rv_reg <= tap_vld_reg[tap_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (w_wr) begin
            w_mem[p2_idx_reg] <= w_new;
        end
        w_rd_reg <= w_mem[idx_reg];
        w_rv_reg <= w_vld_reg[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_vld_reg <= '0;
        end else if (load) begin
            tap_vld_reg[head_next] <= 1'b1;
        end
    end

    // divergence drops every weight back to zero at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_vld_reg <= '0;
        end else if (check && div) begin
            w_vld_reg <= '0;
        end else if (w_wr) begin
            w_vld_reg[p2_idx_reg] <= 1'b1;
        end
    end

    // ---------------- shared MAC pipeline ----------------
    // stage 1: registered store reads; stage 2: product; stage 3: accumulate
    // or weight write-back
    logic                 p1_vld_reg, p2_vld_reg;
    logic                 p1_pass_reg, p2_pass_reg;
    logic [IdxW-1:0]      p1_idx_reg;
    logic signed [SW-1:0] tap1;
    logic signed [WW-1:0] w1;
    logic signed [WW-1:0] w2_reg;
    logic signed [lmsf_pkg::SE_W-1:0]   se_reg;
    logic signed [lmsf_pkg::SE_W-1:0]   mul_a;
    logic signed [lmsf_pkg::PROD_W-1:0] prod_next, prod_reg;

    assign tap1      = tap_rv_reg ? tap_rd_reg : '0;
    assign w1        = w_rv_reg ? w_rd_reg : '0;
    assign mul_a     = p1_pass_reg ? se_reg
                                   : {{(lmsf_pkg::SE_W - WW){w1[WW-1]}}, w1};
    assign prod_next = PrW'(mul_a) * PrW'(tap1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else begin
            p1_vld_reg <= issue;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_pass_reg <= ctrl.pass;
        p1_idx_reg  <= idx_reg;
        p2_pass_reg <= p1_pass_reg;
        p2_idx_reg  <= p1_idx_reg;
        w2_reg      <= w1;
        prod_reg    <= prod_next;
    end

    // ---------------- accumulator ----------------
    logic signed [AccW-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            acc_reg <= '0;
        end else if (p2_vld_reg && !p2_pass_reg) begin
            acc_reg <= acc_reg
                     + {{(AccW - lmsf_pkg::PROD_W){prod_reg[lmsf_pkg::PROD_W-1]}}, prod_reg};
        end
    end

    // ---------------- divergence test and output rounding ----------------
    logic signed [CmpW-1:0] acc_x, bnd_x, nbnd_x;
    logic signed [AccW-1:0] acc_rnd;
    logic signed [SW-1:0]   y_rnd;
    logic signed [SW-1:0]   y_reg;
    logic                   div_reg;
    logic signed [SW-1:0]   err_in_reg;

    assign acc_x   = {acc_reg[AccW-1], acc_reg};
    assign bnd_x   = {{(CmpW - BndW){1'b0}}, limit_reg, {lmsf_pkg::ACC_SHIFT{1'b0}}};
    assign nbnd_x  = -bnd_x;
    assign div     = (acc_x > bnd_x) || (acc_x < nbnd_x);
    // round to nearest, ties up; in range whenever not diverged
    assign acc_rnd = acc_reg + {{(AccW - lmsf_pkg::ACC_SHIFT){1'b0}},
                                1'b1, {(lmsf_pkg::ACC_SHIFT - 1){1'b0}}};
    assign y_rnd   = acc_rnd[lmsf_pkg::ACC_SHIFT + SW - 1 : lmsf_pkg::ACC_SHIFT];

    always_ff @(posedge aclk) begin
        if (load) begin
            err_in_reg <= s_tdata[2*SW-1:SW];
        end
        if (check) begin
            y_reg   <= div ? '0 : y_rnd;
            div_reg <= div;
        end
    end

    // ---------------- step * error ----------------
    logic signed [lmsf_pkg::ERR_W-1:0] err;
    logic signed [lmsf_pkg::ERR_W-1:0] step_s;

    assign err    = {err_in_reg[SW-1], err_in_reg} - {y_reg[SW-1], y_reg};
    assign step_s = {1'b0, step_reg};

    always_ff @(posedge aclk) begin
        if (scale) begin
            se_reg <= SeW'(step_s) * SeW'(err);
        end
    end

    // ---------------- weight write-back ----------------
    // w*2^15 + 2^14 + p, then floor shift: rounds p to Q8.23 and adds in one go
    logic signed [lmsf_pkg::SUM_W-1:0] upd_sum;
    logic signed [lmsf_pkg::SHR_W-1:0] upd_shr;
    logic                              upd_ovf;

    assign upd_sum = {{(lmsf_pkg::SUM_W - WW - lmsf_pkg::UPD_SHIFT){w2_reg[WW-1]}},
                      w2_reg, lmsf_pkg::UPD_HALF}
                   + {prod_reg[lmsf_pkg::PROD_W-1], prod_reg};
    assign upd_shr = upd_sum[lmsf_pkg::SUM_W-1:lmsf_pkg::UPD_SHIFT];
    assign upd_ovf = (upd_shr[lmsf_pkg::SHR_W-1:WW-1] != '0)
                  && (upd_shr[lmsf_pkg::SHR_W-1:WW-1] != '1);
    assign w_new   = upd_ovf ? (upd_shr[lmsf_pkg::SHR_W-1] ? lmsf_pkg::W_MIN : lmsf_pkg::W_MAX)
                             : upd_shr[WW-1:0];
    assign w_wr    = p2_vld_reg && p2_pass_reg;

    // ---------------- output register ----------------
    logic                 m_tvalid_reg;
    logic signed [SW-1:0] m_data_reg;
    logic                 m_div_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= y_reg;
            m_div_reg  <= div_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_div_reg;

    // ---------------- status to sequencer ----------------
    assign stat.in_fire   = in_fire;
    assign stat.idx_last  = idx_last;
    assign stat.pipe_busy = p1_vld_reg || p2_vld_reg;
    assign stat.diverge   = div;
    assign stat.out_free  = out_free;

endmodule

[sv/lmsf_seq.sv]
// Microcode sequencer: step counter, control store and branch logic.
module lmsf_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lmsf_pkg::stat_t      stat_i,
    output lmsf_pkg::ctrl_t      ctrl_o
);

    lmsf_pkg::step_t pc_reg;
    lmsf_pkg::step_t pc_next;
    lmsf_pkg::step_t pc_inc;

    // control store
    always_comb begin
        ctrl_o = '{act: lmsf_pkg::ACT_NONE, pass: 1'b0,
                   cond: lmsf_pkg::COND_NEXT, target: lmsf_pkg::ST_IDLE};
        case (pc_reg)
            lmsf_pkg::ST_IDLE: begin
                ctrl_o.act  = lmsf_pkg::ACT_LOAD;
                ctrl_o.cond = lmsf_pkg::COND_HOLD_IN;
            end
            lmsf_pkg::ST_MAC: begin
                ctrl_o.act    = lmsf_pkg::ACT_ISSUE;
                ctrl_o.cond   = lmsf_pkg::COND_LOOP;
                ctrl_o.target = lmsf_pkg::ST_MAC;
            end
            lmsf_pkg::ST_MAC_DRAIN: begin
                ctrl_o.cond = lmsf_pkg::COND_HOLD_PIPE;
            end
            lmsf_pkg::ST_CHECK: begin
                ctrl_o.act    = lmsf_pkg::ACT_CHECK;
                ctrl_o.cond   = lmsf_pkg::COND_BR_DIV;
                ctrl_o.target = lmsf_pkg::ST_EMIT;
            end
            lmsf_pkg::ST_SCALE: begin
                ctrl_o.act = lmsf_pkg::ACT_SCALE;
            end
            lmsf_pkg::ST_UPD: begin
                ctrl_o.act    = lmsf_pkg::ACT_ISSUE;
                ctrl_o.pass   = 1'b1;
                ctrl_o.cond   = lmsf_pkg::COND_LOOP;
                ctrl_o.target = lmsf_pkg::ST_UPD;
            end
            lmsf_pkg::ST_UPD_DRAIN: begin
                ctrl_o.cond = lmsf_pkg::COND_HOLD_PIPE;
            end
            lmsf_pkg::ST_EMIT: begin
                ctrl_o.act    = lmsf_pkg::ACT_EMIT;
                ctrl_o.cond   = lmsf_pkg::COND_HOLD_OUT;
                ctrl_o.target = lmsf_pkg::ST_IDLE;
            end
            default: begin
                ctrl_o.act = lmsf_pkg::ACT_NONE;
            end
        endcase
    end

    assign pc_inc = lmsf_pkg::step_t'(pc_reg + 3'd1);

    // branch unit
    always_comb begin
        pc_next = pc_reg;
        case (ctrl_o.cond)
            lmsf_pkg::COND_NEXT:      pc_next = pc_inc;
            lmsf_pkg::COND_HOLD_IN:   pc_next = stat_i.in_fire   ? pc_inc        : pc_reg;
            lmsf_pkg::COND_LOOP:      pc_next = stat_i.idx_last  ? pc_inc        : ctrl_o.target;
            lmsf_pkg::COND_HOLD_PIPE: pc_next = stat_i.pipe_busy ? pc_reg        : pc_inc;
            lmsf_pkg::COND_BR_DIV:    pc_next = stat_i.diverge   ? ctrl_o.target : pc_inc;
            lmsf_pkg::COND_HOLD_OUT:  pc_next = stat_i.out_free  ? ctrl_o.target : pc_reg;
            default:                  pc_next = lmsf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= lmsf_pkg::ST_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

[sv/lmsf_checker.sv]
// Port-level checker for the LMS adaptive FIR filter, bound to the top level.
module lmsf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lmsf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a diverged result always reads zero
    a_div_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("diverged result with nonzero output");

    // one item at a time: no acceptance on the cycle after a transfer in
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind lms_adaptive_fir_filter lmsf_checker u_lmsf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
